// ----- design/tsad_pkg.sv -----
// Shared types and constants for the touch sample average and debounce unit.
// Depends on nothing; imported by every module of the block.
package tsad_pkg;

  // Field widths
  localparam int unsigned DATA_W       = 13;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SAMPLE_SHIFT = 3;
  localparam int unsigned DELAY_W      = 4;
  localparam int unsigned COUNT_W      = DELAY_W + 1;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = DATA_W;

  // Register reset values
  localparam logic [DATA_W-1:0]  THRESHOLD_RESET = 13'd100;
  localparam logic [DELAY_W-1:0] DELAY_RESET     = 4'd3;

  // Defaults for the top-level parameters
  localparam int unsigned SAMPLES_AVERAGED_DEF  = 4;
  localparam int unsigned SETTLING_DISCARDS_DEF = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd1;

  // Input word opcodes
  typedef enum logic {
    OP_ADC_WORD  = 1'b0,
    OP_HOST_READ = 1'b1
  } opcode_e;

  // End-of-poll averages handed to the debounce logic
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } poll_t;

  // One host read reply
  typedef struct packed {
    logic              ready_res;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } result_t;

  // Output buffer occupancy, for input flow control
  typedef struct packed {
    logic [1:0] used;
    logic       pop;
  } obuf_status_t;

endpackage

// ----- design/tsad_avg.sv -----
// Per-group sample accumulator: drops settling words, sums shifted samples,
// and produces the Y, X and Z1 averages. Depends on tsad_pkg.
module tsad_avg #(
  parameter int unsigned SAMPLES_AVERAGED  = tsad_pkg::SAMPLES_AVERAGED_DEF,
  parameter int unsigned SETTLING_DISCARDS = tsad_pkg::SETTLING_DISCARDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        word_valid_i,
  input  logic [tsad_pkg::WORD_W-1:0] word_i,
  output tsad_pkg::poll_t             poll_o
);
  import tsad_pkg::*;

  localparam int unsigned GROUP_LEN = SETTLING_DISCARDS + SAMPLES_AVERAGED;
  localparam int unsigned SLOT_W    = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
  localparam int unsigned SUM_W     = DATA_W + $clog2(SAMPLES_AVERAGED);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(GROUP_LEN - 1);
  localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(SETTLING_DISCARDS);

  // Reciprocal of the sample count, rounded up; exact for any sum below 2^SUM_W
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(SAMPLES_AVERAGED);
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES_AVERAGED) - 64'd1) /
             64'(SAMPLES_AVERAGED));

  typedef enum logic [1:0] {
    GRP_Y = 2'd0,
    GRP_X = 2'd1,
    GRP_Z = 2'd2
  } grp_e;

  grp_e              group_q, group_d;
  logic [SLOT_W-1:0] slot_q;
  logic [SUM_W-1:0]  sum_q;
  logic [DATA_W-1:0] y_q, x_q;

  logic              sampling;
  logic              last_slot;
  logic [DATA_W-1:0] sample;
  logic [SUM_W-1:0]  sum_d;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] avg;

  // Running sum and group average
  assign sampling  = (slot_q >= SLOT_FIRST);
  assign last_slot = (slot_q == SLOT_LAST);
  assign sample    = DATA_W'(word_i >> SAMPLE_SHIFT);
  assign sum_d     = sampling ? (sum_q + SUM_W'(sample)) : sum_q;
  assign prod      = PROD_W'(sum_d) * PROD_W'(RECIP);
  assign avg       = DATA_W'(prod >> DIV_SHIFT);

  // Next group in the poll
  always_comb begin
    unique case (group_q)
      GRP_Y:   group_d = GRP_X;
      GRP_X:   group_d = GRP_Z;
      GRP_Z:   group_d = GRP_Y;
      default: group_d = GRP_Y;
    endcase
  end

  // Position, sum and group averages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= GRP_Y;
      slot_q  <= '0;
      sum_q   <= '0;
      y_q     <= '0;
      x_q     <= '0;
    end else if (word_valid_i) begin
      if (last_slot) begin
        slot_q  <= '0;
        sum_q   <= '0;
        group_q <= group_d;
        if (group_q == GRP_Y) y_q <= avg;
        if (group_q == GRP_X) x_q <= avg;
      end else begin
        slot_q <= slot_q + SLOT_W'(1);
        sum_q  <= sum_d;
      end
    end
  end

  // Z1 average goes straight to the debounce logic on the poll's last word
  assign poll_o.done = word_valid_i && last_slot && (group_q == GRP_Z);
  assign poll_o.x    = x_q;
  assign poll_o.y    = y_q;
  assign poll_o.z    = avg;

endmodule

// ----- design/tsad_press.sv -----
// Press debounce: validity check, consecutive poll count, coordinate latch
// and ready flag. Depends on tsad_pkg.
module tsad_press (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsad_pkg::poll_t              poll_i,
  input  logic                         host_read_i,
  input  logic [tsad_pkg::DATA_W-1:0]  threshold_i,
  input  logic [tsad_pkg::DELAY_W-1:0] delay_i,
  output tsad_pkg::result_t            result_o
);
  import tsad_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  logic [DATA_W-1:0]  lx_q, ly_q, lz_q;
  logic               flag_q;

  logic               touch_valid;
  logic [COUNT_W-1:0] delay_ext;
  logic [COUNT_W-1:0] count_inc;
  logic               latch;

  // Touch check and count step
  assign touch_valid = (poll_i.x != '0) && (poll_i.y != '0) && (poll_i.z > threshold_i);
  assign delay_ext   = COUNT_W'(delay_i);
  assign count_inc   = (count_q < delay_ext) ? (count_q + COUNT_W'(1)) : count_q;
  assign latch       = poll_i.done && touch_valid && (count_inc == delay_ext);

  always_comb begin
    count_d = count_q;
    if (poll_i.done) begin
      if (!touch_valid) count_d = '0;
      else if (latch)   count_d = delay_ext + COUNT_W'(1);
      else              count_d = count_inc;
    end
  end

  // Count, latched coordinates and flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
      lz_q    <= '0;
      flag_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (latch) begin
        lx_q   <= poll_i.x;
        ly_q   <= poll_i.y;
        lz_q   <= poll_i.z;
        flag_q <= 1'b1;
      end else if (host_read_i) begin
        flag_q <= 1'b0;
      end
    end
  end

  // Reply seen by a host read this cycle
  assign result_o.ready_res = flag_q;
  assign result_o.x         = lx_q;
  assign result_o.y         = ly_q;
  assign result_o.z         = lz_q;

endmodule

// ----- design/tsad_obuf.sv -----
// Two-entry output buffer (output register plus skid) for host read replies.
// Depends on tsad_pkg.
module tsad_obuf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tsad_pkg::result_t      data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tsad_pkg::result_t      data_o,
  output tsad_pkg::obuf_status_t status_o
);
  import tsad_pkg::*;

  logic    head_valid_q, skid_valid_q;
  result_t head_q, skid_q;
  logic    pop;

  assign pop = head_valid_q && out_ready_i;

  // Control: head is the word on the port, skid catches a push while it stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= push_i;
      end else begin
        head_valid_q <= push_i;
      end
    end else if (!head_valid_q) begin
      head_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
        skid_q <= data_i;
      end else begin
        head_q <= data_i;
      end
    end else if (!head_valid_q) begin
      head_q <= data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o   = head_valid_q;
  assign data_o        = head_q;
  assign status_o.used = {1'b0, head_valid_q} + {1'b0, skid_valid_q};
  assign status_o.pop  = pop;

endmodule

// ----- design/touch_sample_average_debounce_unit.sv -----
// Touch sample average and press debounce unit, top level.
// An ADC word passes through the input register before it updates the poll state; a
// host read reply passes the input register and the output buffer head to the port.
// Throughput: one word per cycle while the two-entry output buffer has room for
// read replies; the buffer holds replies while the output side stalls.
// Reset: asynchronous, active low; clears all state but the input and output payload registers, registers to 100 and 3.
module touch_sample_average_debounce_unit #(
  parameter int unsigned SAMPLES_AVERAGED  = tsad_pkg::SAMPLES_AVERAGED_DEF,
  parameter int unsigned SETTLING_DISCARDS = tsad_pkg::SETTLING_DISCARDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_opcode_i,
  input  logic [tsad_pkg::WORD_W-1:0]     in_adc_word_i,
  // Host read replies
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            out_ready_res_o,
  output logic [tsad_pkg::DATA_W-1:0]     out_touch_x_o,
  output logic [tsad_pkg::DATA_W-1:0]     out_touch_y_o,
  output logic [tsad_pkg::DATA_W-1:0]     out_touch_z_o,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsad_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsad_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tsad_pkg::*;

  logic [DATA_W-1:0]  threshold_q;
  logic [DELAY_W-1:0] delay_q;

  logic              stage_valid_q;
  opcode_e           stage_op_q;
  logic [WORD_W-1:0] stage_word_q;

  logic         in_accept;
  logic         stage_word;
  logic         stage_read;
  logic [1:0]   used_after;
  poll_t        poll;
  result_t      reply;
  result_t      out_data;
  obuf_status_t obuf_status;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      delay_q     <= DELAY_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_THRESHOLD) threshold_q <= cfg_data_i;
      if (cfg_index_i == CFG_DELAY)     delay_q     <= DELAY_W'(cfg_data_i);
    end
  end

  // Input flow control: a word in the stage that is a read needs a buffer slot
  assign stage_word = stage_valid_q && (stage_op_q == OP_ADC_WORD);
  assign stage_read = stage_valid_q && (stage_op_q == OP_HOST_READ);
  assign used_after = obuf_status.used - {1'b0, obuf_status.pop} + {1'b0, stage_read};
  assign in_ready_o = (used_after < 2'd2);
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_op_q   <= opcode_e'(in_opcode_i);
      stage_word_q <= in_adc_word_i;
    end
  end

  tsad_avg #(
    .SAMPLES_AVERAGED  (SAMPLES_AVERAGED),
    .SETTLING_DISCARDS (SETTLING_DISCARDS)
  ) u_avg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (stage_word),
    .word_i       (stage_word_q),
    .poll_o       (poll)
  );

  tsad_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poll_i      (poll),
    .host_read_i (stage_read),
    .threshold_i (threshold_q),
    .delay_i     (delay_q),
    .result_o    (reply)
  );

  tsad_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (stage_read),
    .data_i      (reply),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data),
    .status_o    (obuf_status)
  );

  assign out_ready_res_o = out_data.ready_res;
  assign out_touch_x_o   = out_data.x;
  assign out_touch_y_o   = out_data.y;
  assign out_touch_z_o   = out_data.z;

endmodule
